// ----- src/history_ring_with_cursor_defines.svh -----
// assertion macros for the history ring
`ifndef HISTORY_RING_WITH_CURSOR_DEFINES_SVH
`define HISTORY_RING_WITH_CURSOR_DEFINES_SVH

`ifndef SYNTH
`define HRC_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("history ring check failed");
`define HRC_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("history ring reset check failed");
`else
`define HRC_ASSERT(lbl, prop)
`define HRC_ASSERT_RST(lbl, prop)
`endif

`endif

// ----- src/hrc_pkg.sv -----
`default_nettype none

package hrc_pkg;

  localparam int unsigned ITEM_W = 32;

  typedef enum logic [1:0] {
    FUNC_ADD  = 2'd0,
    FUNC_PREV = 2'd1,
    FUNC_NEXT = 2'd2,
    FUNC_END  = 2'd3
  } func_t;

endpackage

`default_nettype wire

// ----- src/hrc_ram.sv -----
`default_nettype none

module hrc_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- src/history_ring_with_cursor.sv -----
// Navigation history ring with a cursor, holding up to SLOTS-1 entries.
// Request channel: req_valid / req_stall carry func and entry_value; one
// transfer happens on a rising edge with req_valid high and req_stall low.
// func selects add, previous, next or end of iteration.
// Response channel: rsp_valid / rsp_stall carry found and entry_out; every
// request gives exactly one response, in order. entry_out is zero when
// found is low.
// The response passes the registered read of the entry memory, then the
// output register. Throughput: one request per cycle while req_stall is
// low; the pointers live in registers and each request makes at most one
// access to the single write / single read entry memory.
// When the receiver stalls, the output register holds its response and a
// second response waits at the memory read data; only then req_stall rises.
// Reset (rst, synchronous) empties the history, clears the cursor and the
// iteration flag and drops any response in flight. The entry memory is not
// cleared; entries are only read after they were written.
`default_nettype none

module history_ring_with_cursor #(
  parameter int unsigned SLOTS      = 16,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       req_valid,
  output logic                            req_stall,
  input  wire logic [1:0]                 func,
  input  wire logic [hrc_pkg::ITEM_W-1:0] entry_value,
  output logic                            rsp_valid,
  input  wire logic                       rsp_stall,
  output logic                            found,
  output logic      [hrc_pkg::ITEM_W-1:0] entry_out
);

  import hrc_pkg::*;

  `include "history_ring_with_cursor_defines.svh"

  localparam int unsigned PTR_W = $clog2(SLOTS);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(SLOTS - 1);

  function automatic logic [PTR_W-1:0] step_fwd(input logic [PTR_W-1:0] k);
    return (k == LAST) ? '0 : k + PTR_W'(1);
  endfunction

  function automatic logic [PTR_W-1:0] step_back(input logic [PTR_W-1:0] k);
    return (k == '0) ? LAST : k - PTR_W'(1);
  endfunction

  logic [PTR_W-1:0] cursor, oldest, free_slot;
  logic [PTR_W-1:0] cursor_next, oldest_next, free_slot_next;
  logic             in_sequence, in_sequence_next;
  logic             hit;
  logic             accept;
  logic             pend, pend_found;
  logic             move;
  logic             empty, at_newest, full;
  logic [DATA_WIDTH-1:0] rdata;

  assign accept    = req_valid && !req_stall;
  assign move      = pend && (!rsp_valid || !rsp_stall);
  assign req_stall = pend && rsp_valid && rsp_stall;

  assign empty     = (oldest == free_slot);
  assign at_newest = (step_fwd(cursor) == free_slot);
  assign full      = (step_fwd(free_slot) == oldest);

  always_comb begin
    cursor_next      = cursor;
    oldest_next      = oldest;
    free_slot_next   = free_slot;
    in_sequence_next = in_sequence;
    hit              = 1'b0;
    case (func_t'(func))
      FUNC_ADD: begin
        if (empty) begin
          free_slot_next = step_fwd(free_slot);
        end else if (!at_newest) begin
          cursor_next    = step_fwd(cursor);
          free_slot_next = step_fwd(step_fwd(cursor));
        end else begin
          if (full) begin
            oldest_next = step_fwd(oldest);
          end
          cursor_next    = step_fwd(cursor);
          free_slot_next = step_fwd(free_slot);
        end
        in_sequence_next = 1'b0;
      end
      FUNC_PREV: begin
        if (!empty && !(cursor == oldest && in_sequence)) begin
          if (in_sequence) begin
            cursor_next = step_back(cursor);
          end
          in_sequence_next = 1'b1;
          hit              = 1'b1;
        end
      end
      FUNC_NEXT: begin
        if (!empty && !at_newest) begin
          cursor_next      = step_fwd(cursor);
          in_sequence_next = 1'b1;
          hit              = 1'b1;
        end
      end
      default: begin
        in_sequence_next = 1'b0;
      end
    endcase
  end

  hrc_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (SLOTS)
  ) u_ram (
    .clk   (clk),
    .we    (accept && (func_t'(func) == FUNC_ADD)),
    .waddr (cursor_next),
    .wdata (DATA_WIDTH'(entry_value)),
    .re    (accept && hit),
    .raddr (cursor_next),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cursor      <= '0;
      oldest      <= '0;
      free_slot   <= '0;
      in_sequence <= 1'b0;
      pend        <= 1'b0;
      rsp_valid   <= 1'b0;
    end else begin
      if (accept) begin
        cursor      <= cursor_next;
        oldest      <= oldest_next;
        free_slot   <= free_slot_next;
        in_sequence <= in_sequence_next;
      end
      if (accept) begin
        pend <= 1'b1;
      end else if (move) begin
        pend <= 1'b0;
      end
      if (move) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // response payload
  always_ff @(posedge clk) begin
    if (accept) begin
      pend_found <= hit;
    end
    if (move) begin
      found     <= pend_found;
      entry_out <= pend_found ? ITEM_W'(rdata) : '0;
    end
  end

  `HRC_ASSERT(a_accept_fills_read_stage, accept |=> pend)
  `HRC_ASSERT(a_history_never_empties, (oldest != free_slot) |=> (oldest != free_slot))
  `HRC_ASSERT(a_cursor_not_on_free_slot, (oldest != free_slot) |-> (cursor != free_slot))
  `HRC_ASSERT_RST(a_reset_drops_response, rst |=> (!rsp_valid && !pend))

endmodule

`default_nettype wire
